/* design/smac_pkg.sv */
// Shared types, register codes, microcode table and a saturating add helper.
`default_nettype none
package smac_pkg;

  localparam int unsigned DW = 64;
  localparam logic signed [DW-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [DW-1:0] Q_ONE = 64'd1 << 24;

  // Scaling mode of one shared multiply/divide operation.
  localparam logic [1:0] DM_Q24 = 2'd0;
  localparam logic [1:0] DM_Q25 = 2'd1;
  localparam logic [1:0] DM_DIV3 = 2'd2;
  localparam logic [1:0] DM_DVOL = 2'd3;

  // How the result is written back.
  localparam logic [1:0] WM_SET = 2'd0;
  localparam logic [1:0] WM_ACC = 2'd1;
  localparam logic [1:0] WM_SUB = 2'd2;
  localparam logic [1:0] WM_NSET = 2'd3;

  // Register codes of the working register file.
  localparam logic [5:0] RC0 = 6'd0;
  localparam logic [5:0] RC1 = 6'd1;
  localparam logic [5:0] RC2 = 6'd2;
  localparam logic [5:0] RN0 = 6'd3;
  localparam logic [5:0] RN1 = 6'd4;
  localparam logic [5:0] RN2 = 6'd5;
  localparam logic [5:0] RW = 6'd6;
  localparam logic [5:0] RSQ = 6'd7;
  localparam logic [5:0] RCUBE = 6'd8;
  localparam logic [5:0] RT = 6'd9;
  localparam logic [5:0] RD = 6'd10;
  localparam logic [5:0] RU = 6'd11;
  localparam logic [5:0] RVOL = 6'd12;
  localparam logic [5:0] RF0 = 6'd13;
  localparam logic [5:0] RF1 = 6'd14;
  localparam logic [5:0] RF2 = 6'd15;
  localparam logic [5:0] RS0 = 6'd16;
  localparam logic [5:0] RS1 = 6'd17;
  localparam logic [5:0] RS2 = 6'd18;
  localparam logic [5:0] RP0 = 6'd19;
  localparam logic [5:0] RP1 = 6'd20;
  localparam logic [5:0] RP2 = 6'd21;
  localparam logic [5:0] RCOM0 = 6'd22;
  localparam logic [5:0] RCOM1 = 6'd23;
  localparam logic [5:0] RCOM2 = 6'd24;
  localparam logic [5:0] RI0 = 6'd25;
  localparam logic [5:0] RI1 = 6'd26;
  localparam logic [5:0] RI2 = 6'd27;
  localparam logic [5:0] RI3 = 6'd28;
  localparam logic [5:0] RI4 = 6'd29;
  localparam logic [5:0] RI5 = 6'd30;
  localparam logic [5:0] RONE = 6'd31;
  localparam logic [5:0] RQONE = 6'd32;

  localparam logic [5:0] PC_SAMPLE_LAST = 6'd31;
  localparam logic [5:0] PC_FINAL_FIRST = 6'd32;
  localparam logic [5:0] PC_FINAL_LAST = 6'd58;

  typedef struct packed {
    logic [5:0] a_sel;
    logic [5:0] b_sel;
    logic [1:0] dmode;
    logic [5:0] dst;
    logic [1:0] wmode;
  } uop_t;

  typedef struct packed {
    logic start;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic [1:0] dmode;
    logic [DW-1:0] dvsr;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic signed [DW-1:0] value;
  } md_rsp_t;

  function automatic uop_t mk(input logic [5:0] a, input logic [5:0] b,
                              input logic [1:0] m, input logic [5:0] d,
                              input logic [1:0] w);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.dmode = m;
    u.dst = d;
    u.wmode = w;
    return u;
  endfunction

  // Per-sample program (0..31) followed by the result program (32..58).
  function automatic uop_t uop_rom(input logic [5:0] pc);
    uop_t u;
    u = mk(RONE, RONE, DM_Q24, RT, WM_SET);
    case (pc)
      6'd0:  u = mk(RC0, RN0, DM_Q24, RT, WM_SET);
      6'd1:  u = mk(RT, RW, DM_Q24, RVOL, WM_ACC);
      6'd2:  u = mk(RC0, RC0, DM_Q24, RSQ, WM_SET);
      6'd3:  u = mk(RSQ, RC0, DM_Q24, RCUBE, WM_SET);
      6'd4:  u = mk(RSQ, RN0, DM_Q24, RT, WM_SET);
      6'd5:  u = mk(RT, RW, DM_Q25, RF0, WM_ACC);
      6'd6:  u = mk(RCUBE, RN0, DM_Q24, RT, WM_SET);
      6'd7:  u = mk(RT, RW, DM_Q24, RT, WM_SET);
      6'd8:  u = mk(RT, RONE, DM_DIV3, RS0, WM_ACC);
      6'd9:  u = mk(RSQ, RC1, DM_Q24, RT, WM_SET);
      6'd10: u = mk(RT, RN0, DM_Q24, RT, WM_SET);
      6'd11: u = mk(RT, RW, DM_Q25, RP0, WM_ACC);
      6'd12: u = mk(RC1, RC1, DM_Q24, RSQ, WM_SET);
      6'd13: u = mk(RSQ, RC1, DM_Q24, RCUBE, WM_SET);
      6'd14: u = mk(RSQ, RN1, DM_Q24, RT, WM_SET);
      6'd15: u = mk(RT, RW, DM_Q25, RF1, WM_ACC);
      6'd16: u = mk(RCUBE, RN1, DM_Q24, RT, WM_SET);
      6'd17: u = mk(RT, RW, DM_Q24, RT, WM_SET);
      6'd18: u = mk(RT, RONE, DM_DIV3, RS1, WM_ACC);
      6'd19: u = mk(RSQ, RC2, DM_Q24, RT, WM_SET);
      6'd20: u = mk(RT, RN1, DM_Q24, RT, WM_SET);
      6'd21: u = mk(RT, RW, DM_Q25, RP1, WM_ACC);
      6'd22: u = mk(RC2, RC2, DM_Q24, RSQ, WM_SET);
      6'd23: u = mk(RSQ, RC2, DM_Q24, RCUBE, WM_SET);
      6'd24: u = mk(RSQ, RN2, DM_Q24, RT, WM_SET);
      6'd25: u = mk(RT, RW, DM_Q25, RF2, WM_ACC);
      6'd26: u = mk(RCUBE, RN2, DM_Q24, RT, WM_SET);
      6'd27: u = mk(RT, RW, DM_Q24, RT, WM_SET);
      6'd28: u = mk(RT, RONE, DM_DIV3, RS2, WM_ACC);
      6'd29: u = mk(RSQ, RC0, DM_Q24, RT, WM_SET);
      6'd30: u = mk(RT, RN2, DM_Q24, RT, WM_SET);
      6'd31: u = mk(RT, RW, DM_Q25, RP2, WM_ACC);
      6'd32: u = mk(RF0, RQONE, DM_DVOL, RCOM0, WM_SET);
      6'd33: u = mk(RF1, RQONE, DM_DVOL, RCOM1, WM_SET);
      6'd34: u = mk(RF2, RQONE, DM_DVOL, RCOM2, WM_SET);
      6'd35: u = mk(RS1, RQONE, DM_Q24, RI0, WM_SET);
      6'd36: u = mk(RS2, RQONE, DM_Q24, RI0, WM_ACC);
      6'd37: u = mk(RCOM1, RCOM1, DM_Q24, RD, WM_SET);
      6'd38: u = mk(RCOM2, RCOM2, DM_Q24, RD, WM_ACC);
      6'd39: u = mk(RVOL, RD, DM_Q24, RI0, WM_SUB);
      6'd40: u = mk(RP0, RQONE, DM_Q24, RI3, WM_NSET);
      6'd41: u = mk(RVOL, RCOM0, DM_Q24, RU, WM_SET);
      6'd42: u = mk(RU, RCOM1, DM_Q24, RI3, WM_ACC);
      6'd43: u = mk(RS2, RQONE, DM_Q24, RI1, WM_SET);
      6'd44: u = mk(RS0, RQONE, DM_Q24, RI1, WM_ACC);
      6'd45: u = mk(RCOM2, RCOM2, DM_Q24, RD, WM_SET);
      6'd46: u = mk(RCOM0, RCOM0, DM_Q24, RD, WM_ACC);
      6'd47: u = mk(RVOL, RD, DM_Q24, RI1, WM_SUB);
      6'd48: u = mk(RP1, RQONE, DM_Q24, RI4, WM_NSET);
      6'd49: u = mk(RVOL, RCOM1, DM_Q24, RU, WM_SET);
      6'd50: u = mk(RU, RCOM2, DM_Q24, RI4, WM_ACC);
      6'd51: u = mk(RS0, RQONE, DM_Q24, RI2, WM_SET);
      6'd52: u = mk(RS1, RQONE, DM_Q24, RI2, WM_ACC);
      6'd53: u = mk(RCOM0, RCOM0, DM_Q24, RD, WM_SET);
      6'd54: u = mk(RCOM1, RCOM1, DM_Q24, RD, WM_ACC);
      6'd55: u = mk(RVOL, RD, DM_Q24, RI2, WM_SUB);
      6'd56: u = mk(RP2, RQONE, DM_Q24, RI5, WM_NSET);
      6'd57: u = mk(RVOL, RCOM2, DM_Q24, RU, WM_SET);
      6'd58: u = mk(RU, RCOM0, DM_Q24, RI5, WM_ACC);
      default: u = mk(RONE, RONE, DM_Q24, RT, WM_SET);
    endcase
    return u;
  endfunction

  // Saturating add for operands already inside +-SAT_MAX.
  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = $signed({a[DW-1], a}) + $signed({b[DW-1], b});
    if (s > $signed({1'b0, SAT_MAX})) return SAT_MAX;
    if (s < -$signed({1'b0, SAT_MAX})) return -SAT_MAX;
    return s[DW-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/surface_moment_accumulator.sv */
// Top level: sample intake, microcoded sequencer, working registers and result strobe.
`default_nettype none
// A sample transfer happens on a clock edge with start high and busy low. Each
// sample runs a fixed program of 32 operations on one shared multiply/divide unit.
// An operation scaled by a power of two passes once through the multiplier, a
// division by three takes a second pass (the reciprocal product), and a division
// by the volume also runs the 64-step divider unless the volume is zero or the
// quotient overflows. Busy stays high until the sample's program is done, so no
// new sample is taken before then. A sample marked last then runs the sign fix-up
// and a 27-operation result program with three divisions by the volume; the result
// appears in the last busy cycle. The result is shown for exactly one cycle with
// out_valid high; the receiver cannot stall it and must take it in that cycle.
// After the result all sums are cleared for the next solid. All working values
// and results are signed with 24 fraction bits and saturate at +-(2^63-1).
module surface_moment_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic signed [23:0] in_point_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic        [23:0] in_sample_weight,
  input  logic               in_last_sample,
  output logic               out_valid,
  output logic signed [63:0] out_volume,
  output logic signed [63:0] out_area,
  output logic signed [63:0] out_center_x,
  output logic signed [63:0] out_center_y,
  output logic signed [63:0] out_center_z,
  output logic signed [63:0] out_inertia_xx,
  output logic signed [63:0] out_inertia_yy,
  output logic signed [63:0] out_inertia_zz,
  output logic signed [63:0] out_inertia_xy,
  output logic signed [63:0] out_inertia_yz,
  output logic signed [63:0] out_inertia_zx
);
  import smac_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_NEG = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  // Working register file. Sums live here too, so the sequencer reads and writes
  // every operand through the same select.
  typedef struct packed {
    logic [2:0][DW-1:0] c;
    logic [2:0][DW-1:0] n;
    logic [DW-1:0] w;
    logic [DW-1:0] sq;
    logic [DW-1:0] cube;
    logic [DW-1:0] t;
    logic [DW-1:0] d;
    logic [DW-1:0] u;
    logic [DW-1:0] vol;
    logic [DW-1:0] area;
    logic [2:0][DW-1:0] f;
    logic [2:0][DW-1:0] s;
    logic [2:0][DW-1:0] p;
    logic [2:0][DW-1:0] com;
    logic [5:0][DW-1:0] inr;
  } rf_t;

  logic [2:0] st_r, st_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic last_r, last_nxt;
  logic out_valid_r, out_valid_nxt;
  rf_t rf_r, rf_nxt;
  uop_t uop;
  md_req_t req;
  md_rsp_t rsp;
  logic signed [DW-1:0] wb_val, wb_old, wb_new;
  logic accept;

  function automatic logic [DW-1:0] rf_read(input rf_t rf, input logic [5:0] code);
    logic [DW-1:0] v;
    case (code)
      RC0: v = rf.c[0];
      RC1: v = rf.c[1];
      RC2: v = rf.c[2];
      RN0: v = rf.n[0];
      RN1: v = rf.n[1];
      RN2: v = rf.n[2];
      RW: v = rf.w;
      RSQ: v = rf.sq;
      RCUBE: v = rf.cube;
      RT: v = rf.t;
      RD: v = rf.d;
      RU: v = rf.u;
      RVOL: v = rf.vol;
      RF0: v = rf.f[0];
      RF1: v = rf.f[1];
      RF2: v = rf.f[2];
      RS0: v = rf.s[0];
      RS1: v = rf.s[1];
      RS2: v = rf.s[2];
      RP0: v = rf.p[0];
      RP1: v = rf.p[1];
      RP2: v = rf.p[2];
      RCOM0: v = rf.com[0];
      RCOM1: v = rf.com[1];
      RCOM2: v = rf.com[2];
      RI0: v = rf.inr[0];
      RI1: v = rf.inr[1];
      RI2: v = rf.inr[2];
      RI3: v = rf.inr[3];
      RI4: v = rf.inr[4];
      RI5: v = rf.inr[5];
      RONE: v = 64'd1;
      RQONE: v = Q_ONE;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic rf_t rf_write(input rf_t rf, input logic [5:0] code,
                                   input logic [DW-1:0] v);
    rf_t r;
    r = rf;
    case (code)
      RSQ: r.sq = v;
      RCUBE: r.cube = v;
      RT: r.t = v;
      RD: r.d = v;
      RU: r.u = v;
      RVOL: r.vol = v;
      RF0: r.f[0] = v;
      RF1: r.f[1] = v;
      RF2: r.f[2] = v;
      RS0: r.s[0] = v;
      RS1: r.s[1] = v;
      RS2: r.s[2] = v;
      RP0: r.p[0] = v;
      RP1: r.p[1] = v;
      RP2: r.p[2] = v;
      RCOM0: r.com[0] = v;
      RCOM1: r.com[1] = v;
      RCOM2: r.com[2] = v;
      RI0: r.inr[0] = v;
      RI1: r.inr[1] = v;
      RI2: r.inr[2] = v;
      RI3: r.inr[3] = v;
      RI4: r.inr[4] = v;
      RI5: r.inr[5] = v;
      default: r = rf;
    endcase
    return r;
  endfunction

  assign uop = uop_rom(pc_r);
  assign accept = start && (st_r == ST_IDLE);

  smac_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  always_comb begin
    req.start = (st_r == ST_ISSUE);
    req.a = rf_read(rf_r, uop.a_sel);
    req.b = rf_read(rf_r, uop.b_sel);
    req.dmode = uop.dmode;
    req.dvsr = rf_r.vol;

    // A centre taken against a zero volume is defined as zero.
    wb_val = (uop.dmode == DM_DVOL && rf_r.vol == '0) ? '0 : rsp.value;
    wb_old = rf_read(rf_r, uop.dst);
    case (uop.wmode)
      WM_SET: wb_new = wb_val;
      WM_ACC: wb_new = sat_add(wb_old, wb_val);
      WM_SUB: wb_new = sat_add(wb_old, -wb_val);
      WM_NSET: wb_new = -wb_val;
      default: wb_new = wb_val;
    endcase

    st_nxt = st_r;
    pc_nxt = pc_r;
    last_nxt = last_r;
    out_valid_nxt = 1'b0;
    rf_nxt = rf_r;

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          rf_nxt.c[0] = {{28{in_point_x[23]}}, in_point_x, 12'd0};
          rf_nxt.c[1] = {{28{in_point_y[23]}}, in_point_y, 12'd0};
          rf_nxt.c[2] = {{28{in_point_z[23]}}, in_point_z, 12'd0};
          rf_nxt.n[0] = {{38{in_normal_x[15]}}, in_normal_x, 10'd0};
          rf_nxt.n[1] = {{38{in_normal_y[15]}}, in_normal_y, 10'd0};
          rf_nxt.n[2] = {{38{in_normal_z[15]}}, in_normal_z, 10'd0};
          rf_nxt.w = {28'd0, in_sample_weight, 12'd0};
          rf_nxt.area = sat_add(rf_r.area, {28'd0, in_sample_weight, 12'd0});
          last_nxt = in_last_sample;
          pc_nxt = '0;
          st_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: st_nxt = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) begin
          rf_nxt = rf_write(rf_r, uop.dst, wb_new);
          if (pc_r == PC_SAMPLE_LAST) begin
            st_nxt = last_r ? ST_NEG : ST_IDLE;
          end else if (pc_r == PC_FINAL_LAST) begin
            st_nxt = ST_EMIT;
            out_valid_nxt = 1'b1;
          end else begin
            pc_nxt = pc_r + 6'd1;
            st_nxt = ST_ISSUE;
          end
        end
      end
      ST_NEG: begin
        // Inward-facing normals give a negative volume: flip every moment sum.
        if (rf_r.vol[DW-1]) begin
          rf_nxt.vol = -rf_r.vol;
          for (int i = 0; i < 3; i++) begin
            rf_nxt.f[i] = -rf_r.f[i];
            rf_nxt.s[i] = -rf_r.s[i];
            rf_nxt.p[i] = -rf_r.p[i];
          end
        end
        pc_nxt = PC_FINAL_FIRST;
        st_nxt = ST_ISSUE;
      end
      ST_EMIT: begin
        rf_nxt.area = '0;
        rf_nxt.vol = '0;
        for (int i = 0; i < 3; i++) begin
          rf_nxt.f[i] = '0;
          rf_nxt.s[i] = '0;
          rf_nxt.p[i] = '0;
        end
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pc_r <= '0;
      last_r <= 1'b0;
      out_valid_r <= 1'b0;
      rf_r <= '0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
      rf_r <= rf_nxt;
    end
  end

  assign busy = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_volume = rf_r.vol;
  assign out_area = rf_r.area;
  assign out_center_x = rf_r.com[0];
  assign out_center_y = rf_r.com[1];
  assign out_center_z = rf_r.com[2];
  assign out_inertia_xx = rf_r.inr[0];
  assign out_inertia_yy = rf_r.inr[1];
  assign out_inertia_zz = rf_r.inr[2];
  assign out_inertia_xy = rf_r.inr[3];
  assign out_inertia_yz = rf_r.inr[4];
  assign out_inertia_zx = rf_r.inr[5];

  a_result_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == ST_EMIT)
    else $error("result strobe outside the emit cycle");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> rf_r.vol == '0 && rf_r.area == '0)
    else $error("sums not cleared after a result");

  a_volume_flipped: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ISSUE && pc_r >= PC_FINAL_FIRST) |-> !rf_r.vol[DW-1])
    else $error("negative volume in the result program");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after a sample transfer");

endmodule
`default_nettype wire

/* design/smac_muldiv.sv */
// Shared multiply, scale and divide unit: round(|a*b|/d) with sign and saturation.
`default_nettype none
module smac_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  smac_pkg::md_req_t req,
  output smac_pkg::md_rsp_t rsp
);
  import smac_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL = 3'd1;
  localparam logic [2:0] U_POST = 3'd2;
  localparam logic [2:0] U_DIV = 3'd3;
  localparam logic [2:0] U_RND = 3'd4;

  // ceil(2^65 / 3): floor(y * RECIP3 / 2^65) equals floor(y / 3) for y < 2^64.
  localparam logic [DW-1:0] RECIP3 = 64'hAAAA_AAAA_AAAA_AAAB;

  logic [2:0] st_r, st_nxt;
  logic [DW-1:0] ma_r, ma_nxt, mb_r, mb_nxt, dv_r, dv_nxt;
  logic neg_r, neg_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic rcp_r, rcp_nxt;
  logic [2:0] k_r, k_nxt;
  logic [1:0] pk_r, pk_nxt;
  logic pv_r, pv_nxt;
  logic [DW-1:0] pp_r, pp_nxt;
  logic [2*DW-1:0] prod_r, prod_nxt;
  logic [DW-1:0] rem_r, rem_nxt, ql_r, ql_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;
  logic signed [DW-1:0] val_r, val_nxt;

  logic [31:0] a_part, b_part;
  logic [6:0] sh;
  logic [2*DW-1:0] qw;
  logic rb;
  logic [DW:0] r2;
  logic qbit;
  logic rnd;
  logic [DW-2:0] qs;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [DW-1:0] signed_of(input logic [DW-2:0] q,
                                                     input logic n);
    logic signed [DW-1:0] p;
    p = {1'b0, q};
    return n ? -p : p;
  endfunction

  always_comb begin
    a_part = k_r[0] ? ma_r[63:32] : ma_r[31:0];
    b_part = k_r[1] ? mb_r[63:32] : mb_r[31:0];
    sh = {pk_r[1] & pk_r[0], pk_r[1] ^ pk_r[0], 5'd0};
    qw = (mode_r == DM_Q25) ? (prod_r >> 25) : (prod_r >> 24);
    rb = (mode_r == DM_Q25) ? prod_r[24] : prod_r[23];
    r2 = {rem_r, ql_r[DW-1]};
    qbit = (r2 >= {1'b0, dv_r});
    rnd = (rem_r >= (dv_r - rem_r));

    st_nxt = st_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    dv_nxt = dv_r;
    neg_nxt = neg_r;
    mode_nxt = mode_r;
    rcp_nxt = rcp_r;
    k_nxt = k_r;
    pk_nxt = pk_r;
    pv_nxt = 1'b0;
    pp_nxt = pp_r;
    prod_nxt = prod_r;
    rem_nxt = rem_r;
    ql_nxt = ql_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    val_nxt = val_r;
    qs = '0;

    case (st_r)
      U_IDLE: begin
        if (req.start) begin
          ma_nxt = mag(req.a);
          mb_nxt = mag(req.b);
          neg_nxt = req.a[DW-1] ^ req.b[DW-1];
          mode_nxt = req.dmode;
          rcp_nxt = 1'b0;
          dv_nxt = req.dvsr;
          prod_nxt = '0;
          k_nxt = 3'd0;
          st_nxt = U_MUL;
        end
      end
      U_MUL: begin
        if (pv_r) prod_nxt = prod_r + ({{DW{1'b0}}, pp_r} << sh);
        if (k_r != 3'd4) begin
          pp_nxt = a_part * b_part;
          pk_nxt = k_r[1:0];
          pv_nxt = 1'b1;
          k_nxt = k_r + 3'd1;
        end else begin
          st_nxt = U_POST;
        end
      end
      U_POST: begin
        if (rcp_r) begin
          // Second pass of a division by three: the quotient is the top of the product.
          val_nxt = signed_of(prod_r[2*DW-1:DW+1], neg_r);
          done_nxt = 1'b1;
          st_nxt = U_IDLE;
        end else if (mode_r == DM_DIV3) begin
          // round(x / 3) with ties up equals floor((x + 1) / 3); x is below 2^63.
          ma_nxt = prod_r[DW-1:0] + 64'd1;
          mb_nxt = RECIP3;
          rcp_nxt = 1'b1;
          prod_nxt = '0;
          k_nxt = 3'd0;
          st_nxt = U_MUL;
        end else if (mode_r == DM_Q24 || mode_r == DM_Q25) begin
          if ((|qw[2*DW-1:DW-1]) || ((&qw[DW-2:0]) && rb)) qs = SAT_MAX[DW-2:0];
          else qs = qw[DW-2:0] + {{(DW-2){1'b0}}, rb};
          val_nxt = signed_of(qs, neg_r);
          done_nxt = 1'b1;
          st_nxt = U_IDLE;
        end else if (dv_r == '0 || prod_r[2*DW-1:DW] >= dv_r) begin
          val_nxt = signed_of(SAT_MAX[DW-2:0], neg_r);
          done_nxt = 1'b1;
          st_nxt = U_IDLE;
        end else begin
          rem_nxt = prod_r[2*DW-1:DW];
          ql_nxt = prod_r[DW-1:0];
          cnt_nxt = 6'd63;
          st_nxt = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt = qbit ? (r2[DW-1:0] - dv_r) : r2[DW-1:0];
        ql_nxt = {ql_r[DW-2:0], qbit};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) st_nxt = U_RND;
      end
      U_RND: begin
        if (ql_r[DW-1] || ((&ql_r[DW-2:0]) && rnd)) qs = SAT_MAX[DW-2:0];
        else qs = ql_r[DW-2:0] + {{(DW-2){1'b0}}, rnd};
        val_nxt = signed_of(qs, neg_r);
        done_nxt = 1'b1;
        st_nxt = U_IDLE;
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= U_IDLE;
      done_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
      pv_r <= pv_nxt;
    end
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    dv_r <= dv_nxt;
    neg_r <= neg_nxt;
    mode_r <= mode_nxt;
    rcp_r <= rcp_nxt;
    k_r <= k_nxt;
    pk_r <= pk_nxt;
    pp_r <= pp_nxt;
    prod_r <= prod_nxt;
    rem_r <= rem_nxt;
    ql_r <= ql_nxt;
    cnt_r <= cnt_nxt;
    val_r <= val_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.value = val_r;

endmodule
`default_nettype wire
